// File: rtl/core/erm_pkg.sv
package erm_pkg;

    localparam int ANGLE_BITS = 12;
    localparam int FRAC_BITS  = 14;

    // Quarter-wave sine table geometry.
    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int IDX_W   = ANGLE_BITS - 1;

    // Rotation entries are signed Q1.FRAC_BITS and reach +/-2^FRAC_BITS.
    localparam int ENTRY_W = FRAC_BITS + 2;
    localparam int SUM_W   = ENTRY_W + 1;
    localparam int PROD_W  = 2 * ENTRY_W;
    localparam int TR_W    = 32;
    localparam int ONE_FX  = 1 << FRAC_BITS;

    localparam logic signed [TR_W-1:0]   ONE_Q16  = TR_W'(32'h0001_0000);
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0]  SAT_HI   = SUM_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0]  SAT_LO   = -SAT_HI;

    // Queue between the front end and the row engine.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

    typedef logic [FRAC_BITS:0] t_sin_val;
    typedef t_sin_val t_sin_tab [0:QUARTER];

    typedef enum logic [1:0] {
        ROW_X = 2'd0,
        ROW_Y = 2'd1,
        ROW_Z = 2'd2,
        ROW_W = 2'd3
    } t_row;

    // Signed sine and cosine of the three angles plus the translation.
    typedef struct packed {
        logic signed [ENTRY_W-1:0] cf;
        logic signed [ENTRY_W-1:0] sf;
        logic signed [ENTRY_W-1:0] ct;
        logic signed [ENTRY_W-1:0] st;
        logic signed [ENTRY_W-1:0] cp;
        logic signed [ENTRY_W-1:0] sp;
        logic signed [TR_W-1:0]    tx;
        logic signed [TR_W-1:0]    ty;
        logic signed [TR_W-1:0]    tz;
    } t_trig_item;

    // floor(a*b / 2^60), used only while the sine table is elaborated.
    function automatic logic [63:0] f_mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Shift-and-subtract unsigned divide, elaboration only.
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor series of sin(pi*k/(2*QUARTER)) in Q60, rounded to Q.FRAC_BITS.
    function automatic t_sin_tab f_build_sin();
        t_sin_tab    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] den;
        for (int k = 0; k <= QUARTER; k++) begin
            x    = f_mul_q60(PI_Q60, 64'(k) << (61 - ANGLE_BITS));
            x2   = f_mul_q60(x, x);
            term = x;
            sum  = x;
            for (int n = 1; n <= 16; n++) begin
                if (term != 64'd0) begin
                    den  = 64'((2 * n) * (2 * n + 1));
                    term = f_udiv(f_mul_q60(term, x2), den);
                    if ((n & 1) != 0) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
            x      = (sum + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
            tab[k] = x[FRAC_BITS:0];
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = f_build_sin();

    // Two-way product rounded half up back to Q1.FRAC_BITS.
    function automatic logic signed [ENTRY_W-1:0] f_round(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + RND_HALF;
        return s[FRAC_BITS+ENTRY_W-1:FRAC_BITS];
    endfunction

    // Clamp a sum of two entries to +/-2^FRAC_BITS.
    function automatic logic signed [ENTRY_W-1:0] f_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[ENTRY_W-1:0];
    endfunction

endpackage

// File: rtl/core/euler_rigid_transform_matrix.sv
// Builds the 4x4 homogeneous transform R = Rz(yaw) * Ry(pitch) * Rx(roll) with the
// translation in column 3 and emits it as four row results, row 0 first, with the
// final row 0,0,0,1 flagged by o_last_row. Angles are binary angles of ANGLE_BITS
// bits per turn, rotation entries are signed Q1.14 clamped to +/-1.0, and the
// translation passes through unchanged in Q16.16. An accepted request passes the
// registered sine lookup, the queue and the row engine's product, triple-product
// and output registers; the row engine computes one matrix row per cycle while
// i_ready stays high downstream. A four-entry queue sits between the sine lookup
// front end and the row engine, so new requests keep being accepted while it has
// room, even as finished rows wait at the output.
module euler_rigid_transform_matrix (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [erm_pkg::ANGLE_BITS-1:0]     i_yaw_angle,
    input  logic [erm_pkg::ANGLE_BITS-1:0]     i_pitch_angle,
    input  logic [erm_pkg::ANGLE_BITS-1:0]     i_roll_angle,
    input  logic signed [erm_pkg::TR_W-1:0]    i_shift_x,
    input  logic signed [erm_pkg::TR_W-1:0]    i_shift_y,
    input  logic signed [erm_pkg::TR_W-1:0]    i_shift_z,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_row_index,
    output logic signed [erm_pkg::ENTRY_W-1:0] o_entry_col0,
    output logic signed [erm_pkg::ENTRY_W-1:0] o_entry_col1,
    output logic signed [erm_pkg::ENTRY_W-1:0] o_entry_col2,
    output logic signed [erm_pkg::TR_W-1:0]    o_entry_col3,
    output logic                               o_last_row
);
    import erm_pkg::*;

    // Front end to queue: signed sines and cosines of all three angles, each
    // folded out of a quarter-wave ROM, plus the translation.
    logic              w_push;
    t_trig_item        w_push_item;

    // Queue to row engine.
    logic              w_pop;
    logic              w_head_vld;
    t_trig_item        w_head_item;
    logic [QCNT_W-1:0] w_q_count;

    erm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_yaw_angle   (i_yaw_angle),
        .i_pitch_angle (i_pitch_angle),
        .i_roll_angle  (i_roll_angle),
        .i_shift_x     (i_shift_x),
        .i_shift_y     (i_shift_y),
        .i_shift_z     (i_shift_z),
        .i_q_count     (w_q_count),
        .o_push        (w_push),
        .o_push_item   (w_push_item)
    );

    erm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .i_pop       (w_pop),
        .o_head_vld  (w_head_vld),
        .o_head_item (w_head_item),
        .o_count     (w_q_count)
    );

    // The row engine pops a queue entry as its fourth row is issued.
    erm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_vld   (w_head_vld),
        .i_head_item  (w_head_item),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_row_index  (o_row_index),
        .o_entry_col0 (o_entry_col0),
        .o_entry_col1 (o_entry_col1),
        .o_entry_col2 (o_entry_col2),
        .o_entry_col3 (o_entry_col3),
        .o_last_row   (o_last_row)
    );

endmodule

// File: rtl/core/erm_sin_rom.sv
module erm_sin_rom (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [erm_pkg::IDX_W-1:0] i_addr_a,
    input  logic [erm_pkg::IDX_W-1:0] i_addr_b,
    output erm_pkg::t_sin_val     o_data_a,
    output erm_pkg::t_sin_val     o_data_b
);
    import erm_pkg::*;

    t_sin_val r_data_a;
    t_sin_val r_data_b;

    // Only folded quarter-wave addresses (0 to QUARTER) are ever presented.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= SIN_TAB[i_addr_a];
            r_data_b <= SIN_TAB[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

// File: rtl/core/erm_front.sv
module erm_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [erm_pkg::ANGLE_BITS-1:0]     i_yaw_angle,
    input  logic [erm_pkg::ANGLE_BITS-1:0]     i_pitch_angle,
    input  logic [erm_pkg::ANGLE_BITS-1:0]     i_roll_angle,
    input  logic signed [erm_pkg::TR_W-1:0]    i_shift_x,
    input  logic signed [erm_pkg::TR_W-1:0]    i_shift_y,
    input  logic signed [erm_pkg::TR_W-1:0]    i_shift_z,
    input  logic [erm_pkg::QCNT_W-1:0]         i_q_count,
    output logic                               o_push,
    output erm_pkg::t_trig_item                o_push_item
);
    import erm_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             neg;
    } t_sin_addr;

    // Fold an angle onto the quarter-wave table; a cosine is the sine one
    // quadrant further on.
    function automatic t_sin_addr f_sin_addr(input logic [ANGLE_BITS-1:0] angle,
                                             input logic cos_sel);
        t_sin_addr        res;
        logic [1:0]       q;
        logic [IDX_W-1:0] r;
        q       = angle[ANGLE_BITS-1:ANGLE_BITS-2] + {1'b0, cos_sel};
        r       = {1'b0, angle[ANGLE_BITS-3:0]};
        res.idx = q[0] ? (IDX_W'(QUARTER) - r) : r;
        res.neg = q[1];
        return res;
    endfunction

    function automatic logic signed [ENTRY_W-1:0] f_signed(input t_sin_val mag,
                                                          input logic neg);
        logic signed [ENTRY_W-1:0] v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

    logic      w_accept;
    t_sin_addr w_cf_a, w_sf_a, w_ct_a, w_st_a, w_cp_a, w_sp_a;
    t_sin_val  w_cf_m, w_sf_m, w_ct_m, w_st_m, w_cp_m, w_sp_m;

    logic                   r_f_vld;
    logic [5:0]             r_neg;
    logic signed [TR_W-1:0] r_tx, r_ty, r_tz;

    // One request may sit in the lookup stage, so room is counted for it.
    assign o_ready  = (i_q_count + QCNT_W'(r_f_vld)) < QCNT_W'(QDEPTH);
    assign w_accept = i_valid && o_ready;

    assign w_cf_a = f_sin_addr(i_yaw_angle,   1'b1);
    assign w_sf_a = f_sin_addr(i_yaw_angle,   1'b0);
    assign w_ct_a = f_sin_addr(i_pitch_angle, 1'b1);
    assign w_st_a = f_sin_addr(i_pitch_angle, 1'b0);
    assign w_cp_a = f_sin_addr(i_roll_angle,  1'b1);
    assign w_sp_a = f_sin_addr(i_roll_angle,  1'b0);

    erm_sin_rom u_rom_yaw (
        .i_clk    (i_clk),
        .i_en     (w_accept),
        .i_addr_a (w_cf_a.idx),
        .i_addr_b (w_sf_a.idx),
        .o_data_a (w_cf_m),
        .o_data_b (w_sf_m)
    );

    erm_sin_rom u_rom_pitch (
        .i_clk    (i_clk),
        .i_en     (w_accept),
        .i_addr_a (w_ct_a.idx),
        .i_addr_b (w_st_a.idx),
        .o_data_a (w_ct_m),
        .o_data_b (w_st_m)
    );

    erm_sin_rom u_rom_roll (
        .i_clk    (i_clk),
        .i_en     (w_accept),
        .i_addr_a (w_cp_a.idx),
        .i_addr_b (w_sp_a.idx),
        .o_data_a (w_cp_m),
        .o_data_b (w_sp_m)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= {w_cf_a.neg, w_sf_a.neg, w_ct_a.neg, w_st_a.neg, w_cp_a.neg, w_sp_a.neg};
            r_tx  <= i_shift_x;
            r_ty  <= i_shift_y;
            r_tz  <= i_shift_z;
        end
    end

    assign o_push         = r_f_vld;
    assign o_push_item.cf = f_signed(w_cf_m, r_neg[5]);
    assign o_push_item.sf = f_signed(w_sf_m, r_neg[4]);
    assign o_push_item.ct = f_signed(w_ct_m, r_neg[3]);
    assign o_push_item.st = f_signed(w_st_m, r_neg[2]);
    assign o_push_item.cp = f_signed(w_cp_m, r_neg[1]);
    assign o_push_item.sp = f_signed(w_sp_m, r_neg[0]);
    assign o_push_item.tx = r_tx;
    assign o_push_item.ty = r_ty;
    assign o_push_item.tz = r_tz;

endmodule

// File: rtl/core/erm_queue.sv
module erm_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  erm_pkg::t_trig_item        i_push_item,
    input  logic                       i_pop,
    output logic                       o_head_vld,
    output erm_pkg::t_trig_item        o_head_item,
    output logic [erm_pkg::QCNT_W-1:0] o_count
);
    import erm_pkg::*;

    t_trig_item         r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;

    // The front end never pushes into a full queue.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    assign o_head_vld  = (r_count != '0);
    assign o_head_item = r_mem[r_rd_ptr];
    assign o_count     = r_count;

endmodule

// File: rtl/core/erm_back.sv
module erm_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_head_vld,
    input  erm_pkg::t_trig_item                i_head_item,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_row_index,
    output logic signed [erm_pkg::ENTRY_W-1:0] o_entry_col0,
    output logic signed [erm_pkg::ENTRY_W-1:0] o_entry_col1,
    output logic signed [erm_pkg::ENTRY_W-1:0] o_entry_col2,
    output logic signed [erm_pkg::TR_W-1:0]    o_entry_col3,
    output logic                               o_last_row
);
    import erm_pkg::*;

    logic w_adv;
    logic w_issue;

    t_row r_row;

    // Row operand selection.
    logic signed [ENTRY_W-1:0] w_a, w_b;
    logic                      w_sub1, w_sub2, w_tri;
    logic signed [TR_W-1:0]    w_tr;

    // Stage 1: the four two-way products of one row.
    logic                      r_s1_vld;
    t_row                      r_s1_row;
    logic signed [PROD_W-1:0]  r_s1_p0, r_s1_pa, r_s1_pb1, r_s1_pb2;
    logic signed [ENTRY_W-1:0] r_s1_cp, r_s1_sp, r_s1_nst;
    logic                      r_s1_sub1, r_s1_sub2, r_s1_tri;
    logic signed [TR_W-1:0]    r_s1_tr;

    // Stage 2: the triple products.
    logic signed [ENTRY_W-1:0] w_t;
    logic                      r_s2_vld;
    t_row                      r_s2_row;
    logic signed [ENTRY_W-1:0] r_s2_c0, r_s2_q1, r_s2_q2;
    logic signed [PROD_W-1:0]  r_s2_m5, r_s2_m6;
    logic                      r_s2_sub1, r_s2_sub2;
    logic signed [TR_W-1:0]    r_s2_tr;

    // Output stage: sums, saturation, result register.
    logic signed [ENTRY_W-1:0] w_t5, w_t6;
    logic signed [SUM_W-1:0]   w_sum1, w_sum2;
    logic                      r_o_vld;
    t_row                      r_o_row;
    logic signed [ENTRY_W-1:0] r_o_c0, r_o_c1, r_o_c2;
    logic signed [TR_W-1:0]    r_o_c3;

    // The whole row pipeline moves unless a finished row is still unclaimed.
    assign w_adv   = !r_o_vld || i_ready;
    assign w_issue = w_adv && i_head_vld;
    assign o_pop   = w_issue && (r_row == ROW_W);

    // Rows X and Y share one form; row Z drops the triple term and takes
    // minus sin(theta) in column 0, and its two products come out with
    // cos(psi) in the first sum and sin(psi) in the second, so they are
    // placed in the opposite columns; row W is constant.
    always_comb begin
        w_a    = i_head_item.cf;
        w_b    = i_head_item.ct;
        w_sub1 = 1'b0;
        w_sub2 = 1'b0;
        w_tri  = 1'b0;
        w_tr   = ONE_Q16;
        case (r_row)
            ROW_X: begin
                w_a    = i_head_item.cf;
                w_b    = i_head_item.sf;
                w_sub1 = 1'b1;
                w_tri  = 1'b1;
                w_tr   = i_head_item.tx;
            end
            ROW_Y: begin
                w_a    = i_head_item.sf;
                w_b    = i_head_item.cf;
                w_sub2 = 1'b1;
                w_tri  = 1'b1;
                w_tr   = i_head_item.ty;
            end
            ROW_Z: begin
                w_tr = i_head_item.tz;
            end
            ROW_W: begin
                w_tr = ONE_Q16;
            end
            default: begin
                w_tr = ONE_Q16;
            end
        endcase
    end

    assign w_t    = r_s1_tri ? f_round(r_s1_pa) : '0;
    assign w_t5   = f_round(r_s2_m5);
    assign w_t6   = f_round(r_s2_m6);
    assign w_sum1 = r_s2_sub1 ? (SUM_W'(w_t5) - SUM_W'(r_s2_q1))
                              : (SUM_W'(w_t5) + SUM_W'(r_s2_q1));
    assign w_sum2 = r_s2_sub2 ? (SUM_W'(w_t6) - SUM_W'(r_s2_q2))
                              : (SUM_W'(w_t6) + SUM_W'(r_s2_q2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= ROW_X;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (w_adv) begin
            if (w_issue) begin
                r_row <= t_row'(r_row + 2'd1);
            end
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
            r_o_vld  <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_row  <= r_row;
            r_s1_p0   <= w_a * i_head_item.ct;
            r_s1_pa   <= w_a * i_head_item.st;
            r_s1_pb1  <= w_b * i_head_item.cp;
            r_s1_pb2  <= w_b * i_head_item.sp;
            r_s1_cp   <= i_head_item.cp;
            r_s1_sp   <= i_head_item.sp;
            r_s1_nst  <= -i_head_item.st;
            r_s1_sub1 <= w_sub1;
            r_s1_sub2 <= w_sub2;
            r_s1_tri  <= w_tri;
            r_s1_tr   <= w_tr;

            r_s2_row  <= r_s1_row;
            r_s2_c0   <= (r_s1_row == ROW_Z) ? r_s1_nst : f_round(r_s1_p0);
            r_s2_m5   <= w_t * r_s1_sp;
            r_s2_m6   <= w_t * r_s1_cp;
            r_s2_q1   <= f_round(r_s1_pb1);
            r_s2_q2   <= f_round(r_s1_pb2);
            r_s2_sub1 <= r_s1_sub1;
            r_s2_sub2 <= r_s1_sub2;
            r_s2_tr   <= r_s1_tr;

            r_o_row <= r_s2_row;
            r_o_c3  <= r_s2_tr;
            if (r_s2_row == ROW_W) begin
                r_o_c0 <= '0;
                r_o_c1 <= '0;
                r_o_c2 <= '0;
            end else if (r_s2_row == ROW_Z) begin
                r_o_c0 <= r_s2_c0;
                r_o_c1 <= f_sat(w_sum2);
                r_o_c2 <= f_sat(w_sum1);
            end else begin
                r_o_c0 <= r_s2_c0;
                r_o_c1 <= f_sat(w_sum1);
                r_o_c2 <= f_sat(w_sum2);
            end
        end
    end

    assign o_valid      = r_o_vld;
    assign o_row_index  = r_o_row;
    assign o_entry_col0 = r_o_c0;
    assign o_entry_col1 = r_o_c1;
    assign o_entry_col2 = r_o_c2;
    assign o_entry_col3 = r_o_c3;
    assign o_last_row   = (r_o_row == ROW_W);

endmodule

// File: rtl/core/erm_checker.sv
module erm_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               o_ready,
    input  logic [erm_pkg::ANGLE_BITS-1:0]     i_yaw_angle,
    input  logic [erm_pkg::ANGLE_BITS-1:0]     i_pitch_angle,
    input  logic [erm_pkg::ANGLE_BITS-1:0]     i_roll_angle,
    input  logic signed [erm_pkg::TR_W-1:0]    i_shift_x,
    input  logic signed [erm_pkg::TR_W-1:0]    i_shift_y,
    input  logic signed [erm_pkg::TR_W-1:0]    i_shift_z,
    input  logic                               o_valid,
    input  logic                               i_ready,
    input  logic [1:0]                         o_row_index,
    input  logic signed [erm_pkg::ENTRY_W-1:0] o_entry_col0,
    input  logic signed [erm_pkg::ENTRY_W-1:0] o_entry_col1,
    input  logic signed [erm_pkg::ENTRY_W-1:0] o_entry_col2,
    input  logic signed [erm_pkg::TR_W-1:0]    o_entry_col3,
    input  logic                               o_last_row
);
    import erm_pkg::*;

    // A result that is offered stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result withdrawn before it was taken");

    // The last-row flag marks exactly the fourth row.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == ROW_W)))
        else $error("last-row flag does not match the row index");

    // The closing row is always 0, 0, 0, 1.0.
    a_last_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_row) |-> (o_entry_col0 == '0 && o_entry_col1 == '0 &&
                                     o_entry_col2 == '0 && o_entry_col3 == ONE_Q16))
        else $error("closing row is not 0, 0, 0, 1.0");

    // After a row other than the last is taken, any row offered straight after it is its successor.
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_row) |=>
            (!o_valid || o_row_index == $past(o_row_index) + 2'd1))
        else $error("rows of a transform leave out of order");

    // Rotation entries never pass +/-1.0.
    a_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_col0 <= ONE_FX && o_entry_col0 >= -ONE_FX &&
                     o_entry_col1 <= ONE_FX && o_entry_col1 >= -ONE_FX &&
                     o_entry_col2 <= ONE_FX && o_entry_col2 >= -ONE_FX))
        else $error("rotation entry outside +/-1.0");

endmodule

bind euler_rigid_transform_matrix erm_checker u_erm_checker (.*);
